>>> src/hds_pkg.sv
// hds_pkg: shared types, codes and constants for the hash drift scorer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hds_pkg;

    // Beat action codes carried on the slave-side tuser
    localparam int unsigned ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_BYTE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_MARK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd1;

    localparam int unsigned HASH_W = 64;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned VAR_W  = 16;
    localparam int unsigned CNT_W  = 7;    // popcount of 64 bits
    localparam int unsigned LANES  = HASH_W / BYTE_W;
    localparam int unsigned LANE_CNT_W = 4;

    // Master-side tdata: packed_value, variance, tampered, full_hash, zero pad
    localparam int unsigned OUT_BITS = HASH_W + VAR_W + 1 + HASH_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [HASH_W-1:0] OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [VAR_W-1:0]  VAR_MAX      = 16'hFFFF;

    // Finish snapshot handed from the hash state to the scoring pipe
    typedef struct packed {
        logic [HASH_W-1:0] diff;     // running hash ^ baseline
        logic [HASH_W-1:0] ident;    // identity snapshot
        logic [HASH_W-1:0] hash;     // running hash before finish
    } t_fin;

    function automatic logic [LANE_CNT_W-1:0] pop8(input logic [BYTE_W-1:0] v);
        logic [LANE_CNT_W-1:0] n;
        n = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            n = n + LANE_CNT_W'(v[k]);
        end
        return n;
    endfunction

endpackage

>>> src/hds_hash_core.sv
// hds_hash_core: running FNV-1a 64 hash and identity snapshot registers.
// Depends on hds_pkg.
`timescale 1ns / 1ps

module hds_hash_core
    import hds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [BYTE_W-1:0]   i_data_byte,
    output logic [HASH_W-1:0]   o_hash,
    output logic [HASH_W-1:0]   o_ident
);

    logic [HASH_W-1:0] r_hash, n_hash;
    logic [HASH_W-1:0] r_ident, n_ident;
    logic [HASH_W-1:0] w_x;
    logic [HASH_W-1:0] w_folded;

    // prime = 2^40 + 2^8 + 0xB3 ; 0xB3 = 2^7 + 2^5 + 2^4 + 2^1 + 1
    assign w_x = r_hash ^ {{(HASH_W-BYTE_W){1'b0}}, i_data_byte};
    assign w_folded = (w_x << 40) + (w_x << 8) + (w_x << 7) + (w_x << 5)
                    + (w_x << 4) + (w_x << 1) + w_x;

    always_comb begin
        n_hash  = r_hash;
        n_ident = r_ident;
        if (i_accept) begin
            case (i_action)
                ACT_BYTE:   n_hash  = w_folded;
                ACT_MARK:   n_ident = r_hash;
                ACT_FINISH: begin
                    n_hash  = OFFSET_BASIS;
                    n_ident = OFFSET_BASIS;
                end
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= OFFSET_BASIS;
            r_ident <= OFFSET_BASIS;
        end else begin
            r_hash  <= n_hash;
            r_ident <= n_ident;
        end
    end

    assign o_hash  = r_hash;
    assign o_ident = r_ident;

endmodule

>>> src/hds_score_pipe.sv
// hds_score_pipe: capture, per-byte popcount, variance/threshold and output beat.
// Depends on hds_pkg.
`timescale 1ns / 1ps

module hds_score_pipe
    import hds_pkg::*;
#(
    parameter int unsigned VARIANCE_SHIFT    = 48,
    parameter int unsigned DEFAULT_THRESHOLD = 16384
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fin_valid,
    output logic                   o_fin_ready,
    input  t_fin                   i_fin,
    input  logic [VAR_W-1:0]       i_threshold,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_data,
    output logic [VAR_W-1:0]       o_variance,
    output logic                   o_tampered,
    output logic [VAR_W-1:0]       o_eff_threshold
);

    localparam logic [HASH_W-1:0] ID_MASK = (HASH_W'(1) << VARIANCE_SHIFT) - HASH_W'(1);

    // stage 2: captured finish
    logic r_s2v;
    t_fin r_s2;
    // stage 3: lane counts
    logic                  r_s3v;
    logic [LANE_CNT_W-1:0] r_lane [LANES];
    logic [HASH_W-1:0]     r_s3_ident, r_s3_hash;
    // output beat
    logic                   r_ov;
    logic [OUT_TDATA_W-1:0] r_odata;

    logic out_free, s3_free, s2_free;
    logic [CNT_W-1:0] w_cnt;
    logic [VAR_W-1:0] w_var;
    logic [VAR_W-1:0] w_thr;
    logic             w_tamp;
    logic [HASH_W-1:0] w_packed;

    assign out_free = ~r_ov | i_ready;
    assign s3_free  = ~r_s3v | out_free;
    assign s2_free  = ~r_s2v | s3_free;
    assign o_fin_ready = s2_free;

    always_comb begin
        w_cnt = '0;
        for (int l = 0; l < LANES; l++) begin
            w_cnt = w_cnt + CNT_W'(r_lane[l]);
        end
    end

    // count of 64 saturates; below that the scale is a 10-bit shift
    assign w_var = w_cnt[CNT_W-1] ? VAR_MAX : {w_cnt[CNT_W-2:0], 10'b0};
    assign w_thr = (i_threshold == '0) ? VAR_W'(DEFAULT_THRESHOLD) : i_threshold;
    assign w_tamp = (w_var >= w_thr);
    assign w_packed = (HASH_W'(w_var) << VARIANCE_SHIFT) | (r_s3_ident & ID_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2v <= 1'b0;
            r_s3v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (s2_free)  r_s2v <= i_fin_valid;
            if (s3_free)  r_s3v <= r_s2v;
            if (out_free) r_ov  <= r_s3v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && i_fin_valid) begin
            r_s2 <= i_fin;
        end
        if (s3_free && r_s2v) begin
            for (int l = 0; l < LANES; l++) begin
                r_lane[l] <= pop8(r_s2.diff[l*BYTE_W +: BYTE_W]);
            end
            r_s3_ident <= r_s2.ident;
            r_s3_hash  <= r_s2.hash;
        end
        if (out_free && r_s3v) begin
            r_odata <= OUT_TDATA_W'({r_s3_hash, w_tamp, w_var, w_packed});
        end
    end

    assign o_valid         = r_ov;
    assign o_data          = r_odata;
    assign o_variance      = r_odata[HASH_W +: VAR_W];
    assign o_tampered      = r_odata[HASH_W + VAR_W];
    assign o_eff_threshold = w_thr;

endmodule

>>> src/hash_drift_scorer.sv
// hash_drift_scorer: top level, stream ports, configuration registers, checks.
// Depends on hds_pkg, hds_hash_core, hds_score_pipe.
`timescale 1ns / 1ps

// Folds a byte stream into a 64-bit FNV-1a hash, one beat per clock while
// tready is high. Each slave beat carries an action on tuser: byte (fold
// tdata into the hash), mark (copy the running hash into the identity
// snapshot) or finish. Action code 3 is accepted and dropped. A finish emits
// one master beat: the Hamming distance between the running hash and the
// baseline register, times 1024 and saturated at 65535, as the variance; a
// tamper flag when the variance reaches the threshold (zero threshold selects
// DEFAULT_THRESHOLD); the variance packed above the low VARIANCE_SHIFT bits of
// the identity; and the full hash. Finish returns both hashes to the offset
// basis. Throughput is one beat per cycle for any action mix while tready is
// high; the hash loop (xor plus the FNV prime as a shift-add) is combinational.
// Finish results travel a three-register pipe (capture, per-byte popcount,
// sum/score) with its own valid at every stage, so up to three results can
// queue while the master side stalls before the slave side sees tready drop.
// Configuration writes are always ready and should only be issued while idle;
// writes to indexes past the threshold register are ignored.
module hash_drift_scorer
    import hds_pkg::*;
#(
    parameter int unsigned VARIANCE_SHIFT    = 48,
    parameter int unsigned DEFAULT_THRESHOLD = 16384
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [BYTE_W-1:0]      i_s_axis_tdata,   // [7:0] data_byte
    input  logic [ACTION_W-1:0]    i_s_axis_tuser,   // [1:0] action
    // master side
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [63:0] packed_value, [79:64] variance, [80] tampered,
    // [144:81] full_hash, [151:145] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [HASH_W-1:0]      i_cfg_data
);

    logic [HASH_W-1:0] r_baseline;
    logic [VAR_W-1:0]  r_threshold;

    logic              s_accept;
    logic              fin_valid;
    logic              fin_ready;
    logic [HASH_W-1:0] w_hash, w_ident;
    t_fin              w_fin;
    logic [VAR_W-1:0]  w_variance;
    logic              w_tampered;
    logic [VAR_W-1:0]  w_eff_thr;

    // ---- configuration ----
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline  <= '0;
            r_threshold <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BASELINE:  r_baseline  <= i_cfg_data;
                REG_THRESHOLD: r_threshold <= i_cfg_data[VAR_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---- slave handshake ----
    // tready only drops when the finish pipe is fully backed up
    assign o_s_axis_tready = fin_ready;
    assign s_accept        = i_s_axis_tvalid & fin_ready;
    assign fin_valid       = s_accept & (i_s_axis_tuser == ACT_FINISH);

    hds_hash_core u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_action    (i_s_axis_tuser),
        .i_data_byte (i_s_axis_tdata),
        .o_hash      (w_hash),
        .o_ident     (w_ident)
    );

    assign w_fin.diff  = w_hash ^ r_baseline;
    assign w_fin.ident = w_ident;
    assign w_fin.hash  = w_hash;

    hds_score_pipe #(
        .VARIANCE_SHIFT    (VARIANCE_SHIFT),
        .DEFAULT_THRESHOLD (DEFAULT_THRESHOLD)
    ) u_score (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fin_valid     (fin_valid),
        .o_fin_ready     (fin_ready),
        .i_fin           (w_fin),
        .i_threshold     (r_threshold),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_data          (o_m_axis_tdata),
        .o_variance      (w_variance),
        .o_tampered      (w_tampered),
        .o_eff_threshold (w_eff_thr)
    );

    // ---- checks ----
    // finish puts both hashes back to the offset basis
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_valid |=> (w_hash == OFFSET_BASIS) && (w_ident == OFFSET_BASIS))
        else $error("hash state not cleared after finish");

    // mark copies the hash as it stood
    a_mark_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (i_s_axis_tuser == ACT_MARK)) |=> (w_ident == $past(w_hash)))
        else $error("identity snapshot mismatch after mark");

    // variance is a multiple of 1024 or saturated
    a_var_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((w_variance == VAR_MAX) || (w_variance[9:0] == 10'd0)))
        else $error("variance not a scaled count");

    // tamper flag agrees with the threshold in force
    a_tamper_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_tampered == (w_variance >= w_eff_thr)))
        else $error("tamper flag disagrees with variance");

endmodule
